@@ rtl/aar_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package aar_pkg;

  localparam int CORDIC_STAGES_DEF = 16;
  localparam int COORD_WIDTH_DEF   = 32;
  localparam int AXIS_WIDTH        = 16;
  localparam int ANGLE_WIDTH       = 18;
  localparam int ATAN_ENTRIES      = 24;

  // angle units: 1/256 degree
  localparam logic signed [18:0] TURN_UNITS   = 19'sd92160;
  localparam logic signed [18:0] HALF_TURN    = 19'sd46080;
  localparam logic signed [18:0] QUARTER_TURN = 19'sd23040;

  // q30 constants
  localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;
  localparam logic signed [33:0] ONE_Q30         = 34'sd1073741824;

  // pi in q30
  localparam logic [32:0] PI_Q30 = 33'd3373259426;

  // ceil(2^41 / 45): exact floor divide by 45 for numerators below 2^37
  localparam logic [35:0] RECIP_45 = 36'd48867183457;

  // arctangent table, q30
  function automatic logic signed [33:0] atan_q30(input logic [4:0] idx);
    logic signed [33:0] v;
    case (idx)
      5'd0:  v = 34'sd843314856;
      5'd1:  v = 34'sd497837829;
      5'd2:  v = 34'sd263043836;
      5'd3:  v = 34'sd133525158;
      5'd4:  v = 34'sd67021686;
      5'd5:  v = 34'sd33543515;
      5'd6:  v = 34'sd16775850;
      5'd7:  v = 34'sd8388437;
      5'd8:  v = 34'sd4194282;
      5'd9:  v = 34'sd2097149;
      5'd10: v = 34'sd1048575;
      5'd11: v = 34'sd524287;
      5'd12: v = 34'sd262143;
      5'd13: v = 34'sd131071;
      5'd14: v = 34'sd65535;
      5'd15: v = 34'sd32767;
      5'd16: v = 34'sd16383;
      5'd17: v = 34'sd8191;
      5'd18: v = 34'sd4095;
      5'd19: v = 34'sd2047;
      5'd20: v = 34'sd1023;
      5'd21: v = 34'sd511;
      5'd22: v = 34'sd255;
      5'd23: v = 34'sd127;
      default: v = 34'sd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

@@ rtl/aar_cordic.sv @@
`timescale 1ns / 1ps
`default_nettype none
module aar_cordic import aar_pkg::*; #(
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF,
  parameter int SIDE_WIDTH    = 8
) (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         en,
  input  wire                         in_valid,
  input  wire signed [33:0]           in_angle,
  input  wire                         in_neg,
  input  wire        [SIDE_WIDTH-1:0] in_side,
  output logic                        out_valid,
  output logic signed [33:0]          out_cos,
  output logic signed [33:0]          out_sin,
  output logic       [SIDE_WIDTH-1:0] out_side
);

  // one register stage per micro-rotation, plus a final sign stage
  localparam int N = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;

  logic signed [33:0]    xs [0:N];
  logic signed [33:0]    ys [0:N];
  logic signed [34:0]    zs [0:N];
  logic                  ng [0:N];
  logic                  vs [0:N];
  logic [SIDE_WIDTH-1:0] sd [0:N];

  assign xs[0] = CORDIC_GAIN_Q30;
  assign ys[0] = '0;
  assign zs[0] = 35'(in_angle);
  assign ng[0] = in_neg;
  assign vs[0] = in_valid;
  assign sd[0] = in_side;

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic signed [33:0] dx, dy;
    logic signed [34:0] at;
    assign dx = ys[i] >>> i;
    assign dy = xs[i] >>> i;
    assign at = 35'(atan_q30(5'(i)));
    always_ff @(posedge clk) begin
      if (rst) begin
        vs[i+1] <= 1'b0;
      end else if (en) begin
        vs[i+1] <= vs[i];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        if (!zs[i][34]) begin
          xs[i+1] <= xs[i] - dx;
          ys[i+1] <= ys[i] + dy;
          zs[i+1] <= zs[i] - at;
        end else begin
          xs[i+1] <= xs[i] + dx;
          ys[i+1] <= ys[i] - dy;
          zs[i+1] <= zs[i] + at;
        end
        ng[i+1] <= ng[i];
        sd[i+1] <= sd[i];
      end
    end
  end

  // quadrant fold sign
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vs[N];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_cos  <= ng[N] ? -xs[N] : xs[N];
      out_sin  <= ng[N] ? -ys[N] : ys[N];
      out_side <= sd[N];
    end
  end

endmodule
`default_nettype wire

@@ rtl/axis_angle_rotate.sv @@
`timescale 1ns / 1ps
`default_nettype none
// channel  handshake              payload
// in       in_valid / in_ready    vec_x/y/z, axis_x/y/z, angle_deg
// out      out_valid / out_ready  rot_x/y/z, saturated
//
// one transaction per cycle unless the output stalls; data passes through the
// angle stages, the cordic stage chain and the matrix and dot product stages.
// rst clears all valid bits; payload registers are not reset.
// the whole pipeline advances when the output register is empty or taken,
// so a stall holds every stage in place.
module axis_angle_rotate import aar_pkg::*; #(
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF,
  parameter int COORD_WIDTH   = COORD_WIDTH_DEF
) (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           in_valid,
  output logic                          in_ready,
  input  wire signed [COORD_WIDTH-1:0]  vec_x,
  input  wire signed [COORD_WIDTH-1:0]  vec_y,
  input  wire signed [COORD_WIDTH-1:0]  vec_z,
  input  wire signed [AXIS_WIDTH-1:0]   axis_x,
  input  wire signed [AXIS_WIDTH-1:0]   axis_y,
  input  wire signed [AXIS_WIDTH-1:0]   axis_z,
  input  wire signed [ANGLE_WIDTH-1:0]  angle_deg,
  output logic                          out_valid,
  input  wire                           out_ready,
  output logic signed [COORD_WIDTH-1:0] rot_x,
  output logic signed [COORD_WIDTH-1:0] rot_y,
  output logic signed [COORD_WIDTH-1:0] rot_z,
  output logic                          saturated
);

  localparam int CW = COORD_WIDTH;
  localparam int SIDE_W = 3 * CW + 3 * AXIS_WIDTH;

  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // stage a: reduce angle modulo one turn
  logic               a_v;
  logic signed [18:0] a_r;
  logic [SIDE_W-1:0]  a_side;
  logic signed [18:0] r_in, r_mod;
  always_comb begin
    r_in  = 19'(angle_deg);
    r_mod = r_in;
    if (r_mod >= TURN_UNITS) r_mod = r_mod - TURN_UNITS;
    else if (r_mod <= -TURN_UNITS) r_mod = r_mod + TURN_UNITS;
    if (r_mod >= TURN_UNITS) r_mod = r_mod - TURN_UNITS;
    else if (r_mod <= -TURN_UNITS) r_mod = r_mod + TURN_UNITS;
    if (r_mod >= HALF_TURN) r_mod = r_mod - TURN_UNITS;
    else if (r_mod < -HALF_TURN) r_mod = r_mod + TURN_UNITS;
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
    end else if (en) begin
      a_v <= in_valid;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      a_r    <= r_mod;
      a_side <= {vec_x, vec_y, vec_z, axis_x, axis_y, axis_z};
    end
  end

  // stage b: fold to a quarter turn, take magnitude
  logic               b_v, b_neg, b_sgn;
  logic [14:0]        b_mag;
  logic [SIDE_W-1:0]  b_side;
  logic signed [18:0] f_r;
  logic               f_neg;
  always_comb begin
    f_r   = a_r;
    f_neg = 1'b0;
    if (a_r > QUARTER_TURN) begin
      f_r = a_r - HALF_TURN;
      f_neg = 1'b1;
    end else if (a_r < -QUARTER_TURN) begin
      f_r = a_r + HALF_TURN;
      f_neg = 1'b1;
    end
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      b_v <= 1'b0;
    end else if (en) begin
      b_v <= a_v;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      b_neg  <= f_neg;
      b_sgn  <= f_r[18];
      b_mag  <= 15'(f_r[18] ? -f_r : f_r);
      b_side <= a_side;
    end
  end

  // stage c: mag * pi_q30 + half of half turn
  logic               c_v, c_neg, c_sgn;
  logic [46:0]        c_num;
  logic [SIDE_W-1:0]  c_side;
  always_ff @(posedge clk) begin
    if (rst) begin
      c_v <= 1'b0;
    end else if (en) begin
      c_v <= b_v;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      c_num  <= 47'(b_mag) * 47'(PI_Q30) + 47'(23040);
      c_neg  <= b_neg;
      c_sgn  <= b_sgn;
      c_side <= b_side;
    end
  end

  // stage p: divide by half a turn (46080 = 2^10 * 45), drop the 2^10 and
  // multiply by the reciprocal of 45 as two partial products
  logic               p_v, p_neg, p_sgn;
  logic [54:0]        p_hi;
  logic [53:0]        p_lo;
  logic [SIDE_W-1:0]  p_side;
  always_ff @(posedge clk) begin
    if (rst) begin
      p_v <= 1'b0;
    end else if (en) begin
      p_v <= c_v;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      p_hi   <= 55'(c_num[46:28]) * 55'(RECIP_45);
      p_lo   <= 54'(c_num[27:10]) * 54'(RECIP_45);
      p_neg  <= c_neg;
      p_sgn  <= c_sgn;
      p_side <= c_side;
    end
  end

  // stage d: combine partial products, quotient is the top bits above 2^41
  logic               d_v, d_neg;
  logic signed [33:0] d_rad;
  logic [SIDE_W-1:0]  d_side;
  logic [72:0]        q_sum;
  logic [33:0]        q_div;
  always_comb begin
    q_sum = {p_hi, 18'd0} + 73'(p_lo);
    q_div = {2'b00, q_sum[72:41]};
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      d_v <= 1'b0;
    end else if (en) begin
      d_v <= p_v;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      d_rad  <= p_sgn ? -$signed(q_div) : $signed(q_div);
      d_neg  <= p_neg;
      d_side <= p_side;
    end
  end

  // cordic
  logic               k_v;
  logic signed [33:0] k_cos, k_sin;
  logic [SIDE_W-1:0]  k_side;
  aar_cordic #(
    .CORDIC_STAGES(CORDIC_STAGES),
    .SIDE_WIDTH   (SIDE_W)
  ) u_cordic (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (d_v),
    .in_angle (d_rad),
    .in_neg   (d_neg),
    .in_side  (d_side),
    .out_valid(k_v),
    .out_cos  (k_cos),
    .out_sin  (k_sin),
    .out_side (k_side)
  );

  // unpack side data
  logic signed [CW-1:0]         kv [0:2];
  logic signed [AXIS_WIDTH-1:0] kb [0:2];
  assign kv[0] = k_side[SIDE_W-1 -: CW];
  assign kv[1] = k_side[SIDE_W-1-CW -: CW];
  assign kv[2] = k_side[SIDE_W-1-2*CW -: CW];
  assign kb[0] = k_side[3*AXIS_WIDTH-1 -: AXIS_WIDTH];
  assign kb[1] = k_side[2*AXIS_WIDTH-1 -: AXIS_WIDTH];
  assign kb[2] = k_side[AXIS_WIDTH-1 -: AXIS_WIDTH];

  // stage e: axis products, cc, and sine terms b*s
  logic               e_v;
  logic signed [31:0] e_pp [0:2][0:2];
  logic signed [34:0] e_cc;
  logic signed [33:0] e_c;
  logic signed [49:0] e_bs [0:2];
  logic signed [CW-1:0] e_vec [0:2];
  always_ff @(posedge clk) begin
    if (rst) begin
      e_v <= 1'b0;
    end else if (en) begin
      e_v <= k_v;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int p = 0; p < 3; p++) begin
        for (int q = 0; q < 3; q++) begin
          e_pp[p][q] <= 32'(kb[p]) * 32'(kb[q]);
        end
        e_bs[p]  <= 50'(kb[p]) * 50'(k_sin);
        e_vec[p] <= kv[p];
      end
      e_cc <= 35'(ONE_Q30) - 35'(k_cos);
      e_c  <= k_cos;
    end
  end

  // stage f: matrix entries, q58 sum rounded to q26
  logic               f_v;
  logic signed [31:0] f_q [0:2][0:2];
  logic signed [CW-1:0] f_vec [0:2];
  logic signed [67:0] m_term [0:2][0:2];
  logic signed [67:0] m_ctr;
  logic signed [67:0] m_bs [0:2];
  logic signed [67:0] m_sum [0:2][0:2];
  always_comb begin
    m_ctr = 68'(e_c) <<< 28;
    for (int p = 0; p < 3; p++) m_bs[p] = 68'(e_bs[p]) <<< 14;
    for (int p = 0; p < 3; p++) begin
      for (int q = 0; q < 3; q++) begin
        m_term[p][q] = 68'(e_pp[p][q]) * 68'(e_cc);
      end
    end
    m_sum[0][0] = m_term[0][0] + m_ctr;
    m_sum[0][1] = m_term[1][0] + m_bs[2];
    m_sum[0][2] = m_term[2][0] - m_bs[1];
    m_sum[1][0] = m_term[1][0] - m_bs[2];
    m_sum[1][1] = m_term[1][1] + m_ctr;
    m_sum[1][2] = m_term[2][1] + m_bs[0];
    m_sum[2][0] = m_term[0][2] + m_bs[1];
    m_sum[2][1] = m_term[2][1] - m_bs[0];
    m_sum[2][2] = m_term[2][2] + m_ctr;
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      f_v <= 1'b0;
    end else if (en) begin
      f_v <= e_v;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int p = 0; p < 3; p++) begin
        for (int q = 0; q < 3; q++) begin
          f_q[p][q] <= 32'((m_sum[p][q] + (68'sd1 <<< 31)) >>> 32);
        end
        f_vec[p] <= e_vec[p];
      end
    end
  end

  // stage g: partial products, high and low halves of each coordinate
  logic                 g_v;
  logic signed [CW+15:0] g_hi [0:2][0:2];
  logic signed [48:0]   g_lo [0:2][0:2];
  always_ff @(posedge clk) begin
    if (rst) begin
      g_v <= 1'b0;
    end else if (en) begin
      g_v <= f_v;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int p = 0; p < 3; p++) begin
        for (int q = 0; q < 3; q++) begin
          g_hi[p][q] <= (CW+16)'(f_vec[q] >>> 16) * (CW+16)'(f_q[p][q]);
          g_lo[p][q] <= 49'($signed({1'b0, f_vec[q][15:0]})) * 49'(f_q[p][q]);
        end
      end
    end
  end

  // stage h: row sums and rounding to q16
  logic                 h_v;
  logic signed [CW+17:0] h_res [0:2];
  logic signed [50:0]   lo_s;
  logic signed [CW+17:0] hi_s;
  logic signed [CW+17:0] rsum [0:2];
  always_comb begin
    for (int p = 0; p < 3; p++) begin
      hi_s = (CW+18)'(g_hi[p][0]) + (CW+18)'(g_hi[p][1]) + (CW+18)'(g_hi[p][2]);
      lo_s = 51'(g_lo[p][0]) + 51'(g_lo[p][1]) + 51'(g_lo[p][2]) + (51'sd1 <<< 25);
      rsum[p] = (hi_s + (CW+18)'(lo_s >>> 16)) >>> 10;
    end
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      h_v <= 1'b0;
    end else if (en) begin
      h_v <= g_v;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int p = 0; p < 3; p++) h_res[p] <= rsum[p];
    end
  end

  // output register with saturation
  localparam logic signed [CW+17:0] MAXV = (CW+18)'({1'b0, {(CW-1){1'b1}}});
  localparam logic signed [CW+17:0] MINV = -MAXV - (CW+18)'(1);
  logic signed [CW-1:0] sat_v [0:2];
  logic                 sat_any;
  always_comb begin
    sat_any = 1'b0;
    for (int p = 0; p < 3; p++) begin
      if (h_res[p] > MAXV) begin
        sat_v[p] = MAXV[CW-1:0];
        sat_any = 1'b1;
      end else if (h_res[p] < MINV) begin
        sat_v[p] = MINV[CW-1:0];
        sat_any = 1'b1;
      end else begin
        sat_v[p] = h_res[p][CW-1:0];
      end
    end
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= h_v;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      rot_x     <= sat_v[0];
      rot_y     <= sat_v[1];
      rot_z     <= sat_v[2];
      saturated <= sat_any;
    end
  end

endmodule
`default_nettype wire
